>>> hdl/pla_pkg.sv
// shared types and constants for the programmable and-or-xor logic array
// no dependencies; imported by programmable_logic_array_eval_top and its testbench
package pla_pkg;

  localparam int TERM_DEPTH_DEF = 512;

  localparam int IN_W      = 31;
  localparam int IDX_W     = 9;
  localparam int OUT_W     = 32;
  localparam int LIT_W     = 2 * IN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [IN_W-1:0]  INPUT_ENABLE_RST = IN_W'(32'h0000_FFFF);
  localparam logic [IDX_W-1:0] TERM_COUNT_RST   = IDX_W'(48);
  localparam logic [OUT_W-1:0] OUT_INVERT_RST   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_ENABLE = 2'd0,
    REG_TERM_COUNT   = 2'd1,
    REG_OUT_INVERT   = 2'd2
  } pla_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } pla_state_t;

endpackage

>>> hdl/pla_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing; used for the term stores of the logic array
module pla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/programmable_logic_array_eval_top.sv
// top level of the programmable and-or-xor logic array: config registers,
// evaluation sequencer and output register; uses pla_pkg and pla_ram
//
// usage:
//   in_* is a valid/ready request channel. in_action = 1 writes one product
//   term (fuse masks and output mask) at in_term_index and gives no result.
//   in_action = 0 evaluates in_input_value over the first
//   term_count terms and gives one out_output_bits request.
//   evaluation reads one term per cycle from the term ram, over
//   min(term_count, TERM_DEPTH) terms; in_ready stays low from the request
//   until the result is loaded into the output register.
//   the result sits in an output register; a new request is taken while it
//   waits, and a following evaluation holds in its final step until the
//   receiver takes the old result.
//   cfg_we writes register cfg_index (0 input enable, 1 term count,
//   2 output invert); write it only while the block is idle: the block does not enforce it.
//   synchronous reset restores the register defaults and empties the output;
//   the term ram is not cleared and must be written before it is evaluated.
module programmable_logic_array_eval_top #(
  parameter int TERM_DEPTH = pla_pkg::TERM_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [pla_pkg::IN_W-1:0]      in_input_value,
  input  logic [pla_pkg::IDX_W-1:0]     in_term_index,
  input  logic [pla_pkg::IN_W-1:0]      in_true_fuse_mask,
  input  logic [pla_pkg::IN_W-1:0]      in_complement_fuse_mask,
  input  logic [pla_pkg::OUT_W-1:0]     in_term_output_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pla_pkg::OUT_W-1:0]     out_output_bits,
  input  logic                          cfg_we,
  input  logic [pla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pla_pkg::CFG_W-1:0]     cfg_wdata
);

  import pla_pkg::*;

  localparam int AW = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
  localparam int CW = $clog2(TERM_DEPTH + 1);

  logic [IN_W-1:0]  en_mask_r;
  logic [IDX_W-1:0] term_count_r;
  logic [OUT_W-1:0] invert_r;

  pla_state_t state_r, state_nxt;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    lim_r, lim_nxt;
  logic [IN_W-1:0]  val_r, val_nxt;
  logic [OUT_W-1:0] sum_r, sum_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [OUT_W-1:0] out_bits_r, out_bits_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_take;
  logic             issue;
  logic             out_free;
  logic             ram_we;
  logic [LIT_W-1:0] rd_lit;
  logic [OUT_W-1:0] rd_omask;
  logic [IN_W-1:0]  lit_true;
  logic [IN_W-1:0]  lit_cmp;
  logic             term_hit;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_mask_r    <= INPUT_ENABLE_RST;
      term_count_r <= TERM_COUNT_RST;
      invert_r     <= OUT_INVERT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_ENABLE: en_mask_r    <= cfg_wdata[IN_W-1:0];
        REG_TERM_COUNT:   term_count_r <= cfg_wdata[IDX_W-1:0];
        REG_OUT_INVERT:   invert_r     <= cfg_wdata[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // term stores
  pla_ram #(
    .WIDTH(LIT_W),
    .DEPTH(TERM_DEPTH)
  ) u_lit_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(AW'(in_term_index)),
    .wr_data({in_complement_fuse_mask, in_true_fuse_mask}),
    .rd_en  (issue),
    .rd_addr(cnt_r[AW-1:0]),
    .rd_data(rd_lit)
  );

  pla_ram #(
    .WIDTH(OUT_W),
    .DEPTH(TERM_DEPTH)
  ) u_out_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(AW'(in_term_index)),
    .wr_data(in_term_output_mask),
    .rd_en  (issue),
    .rd_addr(cnt_r[AW-1:0]),
    .rd_data(rd_omask)
  );

  // product term match
  assign lit_true = rd_lit[IN_W-1:0];
  assign lit_cmp  = rd_lit[LIT_W-1:IN_W];
  assign term_hit = (((lit_true | val_r) & en_mask_r) == en_mask_r) &&
                    (((lit_cmp | ~val_r) & en_mask_r) == en_mask_r);

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_action) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == lim_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  issue    = (cnt_r != lim_r);
      ST_DONE: ;
      default: ;
    endcase
  end

  assign in_take = in_valid && in_ready;
  assign ram_we  = in_take && in_action &&
                   (32'(in_term_index) < 32'(TERM_DEPTH));

  // datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    val_nxt       = val_r;
    sum_nxt       = sum_r;
    rd_vld_nxt    = issue;
    out_bits_nxt  = out_bits_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_take && !in_action) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      val_nxt = in_input_value;
      if (32'(term_count_r) > 32'(TERM_DEPTH)) begin
        lim_nxt = CW'(TERM_DEPTH);
      end else begin
        lim_nxt = CW'(term_count_r);
      end
    end
    if (issue) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (rd_vld_r && term_hit) begin
      sum_nxt = sum_r | rd_omask;
    end
    if (state_r == ST_DONE && out_free) begin
      out_bits_nxt  = sum_r ^ invert_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      lim_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      lim_r       <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    sum_r      <= sum_nxt;
    out_bits_r <= out_bits_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_output_bits = out_bits_r;

endmodule

>>> tb/sv/tb_programmable_logic_array_eval_top.sv
// self-checking testbench for programmable_logic_array_eval_top: term writes and
// evaluations over valid/ready, predicted by an in-bench and-or-xor term model
// depends on pla_pkg and the programmable_logic_array_eval_top rtl only
module tb_programmable_logic_array_eval_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pla_pkg::*;

  localparam int DEPTH        = TERM_DEPTH_DEF;
  localparam int IDLE_PCT     = 10;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 520;
  localparam int RANDOM_ITEMS = 600;
  localparam int POOL_SIZE    = 8;

  typedef enum logic {
    ACT_EVAL  = 1'b0,
    ACT_WRITE = 1'b1
  } pla_action_t;

  typedef struct {
    pla_action_t      action;
    logic [IN_W-1:0]  input_value;
    logic [IDX_W-1:0] term_index;
    logic [IN_W-1:0]  true_fuse;
    logic [IN_W-1:0]  comp_fuse;
    logic [OUT_W-1:0] term_out;
  } pla_request_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = 1'b0;
  logic [IN_W-1:0]      in_input_value = '0;
  logic [IDX_W-1:0]     in_term_index = '0;
  logic [IN_W-1:0]      in_true_fuse_mask = '0;
  logic [IN_W-1:0]      in_complement_fuse_mask = '0;
  logic [OUT_W-1:0]     in_term_output_mask = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     out_output_bits;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // predicted block state
  logic [IN_W-1:0]  enable_reg = INPUT_ENABLE_RST;
  logic [IDX_W-1:0] count_reg  = TERM_COUNT_RST;
  logic [OUT_W-1:0] invert_reg = OUT_INVERT_RST;
  logic [IN_W-1:0]  stored_true_fuse[DEPTH];
  logic [IN_W-1:0]  stored_comp_fuse[DEPTH];
  logic [OUT_W-1:0] stored_out_mask[DEPTH];

  pla_request_t     pending_requests[$];
  pla_request_t     active_req;
  logic [OUT_W-1:0] expected_output_bits[$];
  bit               term_filled[DEPTH];
  logic [IN_W-1:0]  value_pool[POOL_SIZE];
  int               cur_count = 0;
  int               src_idle_pct = IDLE_PCT;
  int               sink_stall_pct = IDLE_PCT;
  int               error_count = 0;
  int               quiet_cycles = 0;

  always #4 clk = ~clk;

  programmable_logic_array_eval_top DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_action               (in_action),
    .in_input_value          (in_input_value),
    .in_term_index           (in_term_index),
    .in_true_fuse_mask       (in_true_fuse_mask),
    .in_complement_fuse_mask (in_complement_fuse_mask),
    .in_term_output_mask     (in_term_output_mask),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_output_bits         (out_output_bits),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  function automatic logic [OUT_W-1:0] sum_of_products(logic [IN_W-1:0] v);
    logic [OUT_W-1:0] acc;
    int n;
    acc = '0;
    n = (int'(count_reg) > DEPTH) ? DEPTH : int'(count_reg);
    for (int t = 0; t < n; t++) begin
      if ((((stored_true_fuse[t] | v) & enable_reg) == enable_reg) &&
          (((stored_comp_fuse[t] | ~v) & enable_reg) == enable_reg))
        acc |= stored_out_mask[t];
    end
    return acc ^ invert_reg;
  endfunction

  function automatic void apply_request(pla_request_t r);
    if (r.action == ACT_WRITE) begin
      stored_true_fuse[r.term_index] = r.true_fuse;
      stored_comp_fuse[r.term_index] = r.comp_fuse;
      stored_out_mask[r.term_index]  = r.term_out;
    end else begin
      expected_output_bits.push_back(sum_of_products(r.input_value));
    end
  endfunction

  function automatic pla_request_t noisy_request(pla_action_t act);
    pla_request_t r;
    r.action      = act;
    r.input_value = IN_W'($urandom);
    r.term_index  = IDX_W'($urandom);
    r.true_fuse   = IN_W'($urandom);
    r.comp_fuse   = IN_W'($urandom);
    r.term_out    = $urandom;
    return r;
  endfunction

  function automatic void push_write(int idx, logic [IN_W-1:0] t, logic [IN_W-1:0] c,
                                     logic [OUT_W-1:0] o);
    pla_request_t r;
    r = noisy_request(ACT_WRITE);
    r.term_index = IDX_W'(idx);
    r.true_fuse  = t;
    r.comp_fuse  = c;
    r.term_out   = o;
    pending_requests.push_back(r);
    term_filled[idx] = 1'b1;
  endfunction

  function automatic void push_eval(logic [IN_W-1:0] v);
    pla_request_t r;
    r = noisy_request(ACT_EVAL);
    r.input_value = v;
    pending_requests.push_back(r);
  endfunction

  // mostly terms built around pool values so evaluations hit them
  function automatic void push_term(int idx);
    logic [IN_W-1:0]  care;
    logic [IN_W-1:0]  val;
    logic [IN_W-1:0]  t;
    logic [IN_W-1:0]  c;
    logic [OUT_W-1:0] o;
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      care = IN_W'($urandom);
      repeat ($urandom_range(3)) care &= IN_W'($urandom);
      val = value_pool[$urandom_range(POOL_SIZE - 1)];
      t = ~(care & val);
      c = ~(care & ~val);
    end else if (kind < 8) begin
      t = IN_W'($urandom);
      c = IN_W'($urandom);
    end else if (kind == 8) begin
      t = '1;
      c = '1;
    end else begin
      t = IN_W'($urandom & $urandom);
      c = IN_W'($urandom & $urandom);
    end
    case ($urandom_range(3))
      0: o = OUT_W'(1) << $urandom_range(OUT_W - 1);
      1: o = $urandom;
      2: o = $urandom & $urandom;
      default: o = '0;
    endcase
    push_write(idx, t, c, o);
  endfunction

  function automatic logic [IN_W-1:0] pick_eval_value();
    logic [IN_W-1:0] v;
    if ($urandom_range(9) < 6) begin
      v = value_pool[$urandom_range(POOL_SIZE - 1)];
      if ($urandom_range(1) == 1)
        v ^= IN_W'(1) << $urandom_range(IN_W - 1);
    end else begin
      v = IN_W'($urandom);
    end
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_enable();
    logic [CFG_W-1:0] e;
    case ($urandom_range(4))
      0: e = 32'h7FFF_FFFF;
      1: e = 32'h0000_FFFF & $urandom;
      2: e = $urandom & $urandom;
      3: e = $urandom;
      default: e = $urandom & $urandom & $urandom;
    endcase
    e[CFG_W-1] = 1'($urandom_range(1));
    return e;
  endfunction

  task automatic write_reg(pla_reg_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INPUT_ENABLE: enable_reg = data[IN_W-1:0];
      REG_TERM_COUNT:   count_reg = data[IDX_W-1:0];
      REG_OUT_INVERT:   invert_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_output_bits.size() != 0);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        apply_request(active_req);
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          active_req = pending_requests.pop_front();
          in_valid                <= 1'b1;
          in_action               <= active_req.action;
          in_input_value          <= active_req.input_value;
          in_term_index           <= active_req.term_index;
          in_true_fuse_mask       <= active_req.true_fuse;
          in_complement_fuse_mask <= active_req.comp_fuse;
          in_term_output_mask     <= active_req.term_out;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_output_bits.size() == 0) begin
          $error("output_bits unexpected request: expected none actual %08h", out_output_bits);
          error_count++;
        end else if (expected_output_bits[0] !== out_output_bits) begin
          $error("output_bits mismatch: expected %08h actual %08h",
                 expected_output_bits[0], out_output_bits);
          error_count++;
          void'(expected_output_bits.pop_front());
        end else begin
          void'(expected_output_bits.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase;
    int counted;
    int n_items;
    int idx;
    logic [CFG_W-1:0] en_w;
    logic [CFG_W-1:0] cnt_w;
    logic [CFG_W-1:0] inv_w;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset enable and invert, small term count
    write_reg(REG_TERM_COUNT, 32'd8);
    cur_count = 8;
    push_write(0, '1, '1, 32'h0000_0001);
    push_write(1, '0, '0, 32'h8000_0000);
    push_write(2, ~IN_W'(1), '1, 32'h0000_0002);
    push_write(3, '1, ~IN_W'(1), 32'h0000_0004);
    push_write(4, ~(IN_W'(1) << 16), '1, 32'h0000_0008);
    push_write(5, 31'h7FFF_0000, '1, 32'hFFFF_0000);
    push_write(6, ~(IN_W'(1) << 15), ~(IN_W'(1) << 30), 32'h0000_0010);
    push_write(7, '0, '1, 32'hFFFF_FFFF);
    push_write(511, IN_W'($urandom), IN_W'($urandom), 32'hA5A5_A5A5);
    push_write(256, '1, '1, '0);
    push_eval('0);
    push_eval('1);
    push_eval(31'h0000_FFFF);
    push_eval(31'h0001_0000);
    push_eval(31'h0000_8000);
    push_eval(31'h0000_0001);
    push_eval(31'h7FFF_0000);
    push_eval(31'h4000_0000);

    counted = 0;
    for (phase = 0; counted < RANDOM_ITEMS || phase < 7; phase++) begin
      en_w  = pick_enable();
      cnt_w = $urandom;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: cnt_w[IDX_W-1:0] = IDX_W'($urandom_range(32, 1));
        7, 8:                cnt_w[IDX_W-1:0] = IDX_W'($urandom_range(128, 33));
        default:             cnt_w[IDX_W-1:0] = '0;
      endcase
      inv_w = ($urandom_range(3) == 0) ? '0 : $urandom;
      case (phase)
        0: en_w = '0;
        1: begin
          en_w  = '1;
          inv_w = '1;
        end
        2: cnt_w[IDX_W-1:0] = '0;
        3: cnt_w[IDX_W-1:0] = 9'd1;
        6: cnt_w[IDX_W-1:0] = 9'd511;
        default: ;
      endcase

      wait_idle();
      repeat (4) @(posedge clk);
      write_reg(REG_INPUT_ENABLE, en_w);
      write_reg(REG_TERM_COUNT, cnt_w);
      write_reg(REG_OUT_INVERT, inv_w);
      cur_count      = int'(cnt_w[IDX_W-1:0]);
      src_idle_pct   = (phase == 4) ? 0 : IDLE_PCT;
      sink_stall_pct = (phase == 4) ? 0 : IDLE_PCT;

      foreach (value_pool[p]) value_pool[p] = IN_W'($urandom);
      for (int t = 0; t < cur_count; t++) begin
        if (!term_filled[t]) begin
          push_term(t);
          counted++;
        end
      end

      n_items = (cur_count > 128) ? 8 : $urandom_range(60, 20);
      for (int k = 0; k < n_items; k++) begin
        if (phase % 4 == 2 && k == n_items / 2)
          wait_idle();
        if ($urandom_range(99) < 35) begin
          if (cur_count == 0 || $urandom_range(3) == 0)
            idx = $urandom_range(DEPTH - 1);
          else
            idx = $urandom_range(cur_count - 1);
          push_term(idx);
        end else begin
          push_eval(pick_eval_value());
        end
        counted++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/pla_pkg.sv
hdl/pla_ram.sv
hdl/programmable_logic_array_eval_top.sv
tb/sv/tb_programmable_logic_array_eval_top.sv
